// ----- sv/bb_pkg.sv -----
// ----------------------------------------------------------------------------
// bb_pkg
// Types and constants shared by the 3x3 box blur: pixel and result words,
// window words passed from front to back, register indexes, divide constants.
// ----------------------------------------------------------------------------
package bb_pkg;

	localparam int unsigned CFG_IDX_W   = 4;
	localparam int unsigned CFG_DATA_W  = 13;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	localparam logic [11:0] WIDTH_RESET  = 12'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;
	localparam int unsigned MIN_DIM      = 3;
	localparam int unsigned MAX_HEIGHT   = 4096;

	localparam int unsigned SUM_W        = 12;
	localparam logic [12:0] ROUND_BIAS   = 13'd4;
	localparam logic [12:0] RECIP_NINE   = 13'd7282;
	localparam int unsigned RECIP_SHIFT  = 16;

	localparam int unsigned QUEUE_DEPTH  = 4;
	localparam int unsigned QAW          = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCW          = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pixel_t;

	typedef struct packed {
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
		logic [10:0] center_column;
		logic [11:0] center_row;
	} result_t;

	typedef struct packed {
		pixel_t [8:0] win;
		logic [10:0]  center_column;
		logic [11:0]  center_row;
	} win_item_t;

	typedef struct packed {
		logic      valid;
		win_item_t item;
	} win_push_t;

endpackage

// ----- sv/bb_front.sv -----
// ----------------------------------------------------------------------------
// bb_front
// Pixel intake: frame counters, configuration registers, two line stores and
// the 3x3 window. Interior pixels hand their window word to the queue.
// ----------------------------------------------------------------------------
module bb_front #(
	parameter int unsigned MAX_WIDTH = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  bb_pkg::pixel_t                  pixel,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bb_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                            q_pop,
	output bb_pkg::win_push_t               q_push
);
	import bb_pkg::*;

	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned CW = (WW > 12) ? WW : 12;

	logic [11:0]   image_width_q;
	logic [12:0]   image_height_q;
	logic [CW-1:0] w_eff;
	logic [12:0]   h_eff;
	logic [AW-1:0] col_q;
	logic [11:0]   row_q;
	logic          col_last;
	logic          row_last;
	logic          accept;
	logic          emit;
	logic [QCW-1:0] credit_q;

	pixel_t        upper_mem  [MAX_WIDTH];
	pixel_t        middle_mem [MAX_WIDTH];

	logic          v_s1;
	logic          emit_s1;
	logic [AW-1:0] addr_s1;
	pixel_t        pix_s1;
	pixel_t        up_rd_s1;
	pixel_t        mid_rd_s1;
	logic [10:0]   ccol_s1;
	logic [11:0]   crow_s1;
	pixel_t [8:0]  win_q;
	pixel_t [8:0]  win_next;

	always_comb begin
		if (CW'(image_width_q) < CW'(MIN_DIM)) begin
			w_eff = CW'(MIN_DIM);
		end else if (CW'(image_width_q) > CW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(image_width_q);
		end
		if (image_height_q < 13'(MIN_DIM)) begin
			h_eff = 13'(MIN_DIM);
		end else if (image_height_q > 13'(MAX_HEIGHT)) begin
			h_eff = 13'(MAX_HEIGHT);
		end else begin
			h_eff = image_height_q;
		end
	end

	assign col_last  = (CW'(col_q) + CW'(1)) >= w_eff;
	assign row_last  = (13'(row_q) + 13'd1) >= h_eff;
	assign full      = credit_q >= QCW'(QUEUE_DEPTH);
	assign accept    = push && !full;
	assign emit      = (col_q >= AW'(2)) && (row_q >= 12'd2);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
			col_q          <= '0;
			row_q          <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data[11:0];
					col_q         <= '0;
					row_q         <= '0;
				end
				REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data;
					col_q          <= '0;
					row_q          <= '0;
				end
				default: ;
			endcase
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? 12'd0 : row_q + 12'd1;
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// count window words in flight or queued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + QCW'(accept && emit) - QCW'(q_pop);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
		end else begin
			v_s1    <= accept;
			emit_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= col_q;
			pix_s1  <= pixel;
			ccol_s1 <= 11'(col_q - AW'(1));
			crow_s1 <= row_q - 12'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			up_rd_s1  <= upper_mem[col_q];
			mid_rd_s1 <= middle_mem[col_q];
		end
		if (v_s1) begin
			upper_mem[addr_s1]  <= mid_rd_s1;
			middle_mem[addr_s1] <= pix_s1;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_next[r*3 + 0] = win_q[r*3 + 1];
			win_next[r*3 + 1] = win_q[r*3 + 2];
		end
		win_next[2] = up_rd_s1;
		win_next[5] = mid_rd_s1;
		win_next[8] = pix_s1;
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			win_q <= win_next;
		end
	end

	assign q_push.valid              = v_s1 && emit_s1;
	assign q_push.item.win           = win_next;
	assign q_push.item.center_column = ccol_s1;
	assign q_push.item.center_row    = crow_s1;

endmodule

// ----- sv/bb_queue.sv -----
// ----------------------------------------------------------------------------
// bb_queue
// Short queue of window words between the intake and the arithmetic back end.
// ----------------------------------------------------------------------------
module bb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  bb_pkg::win_push_t wr,
	input  logic              pop,
	output logic              valid,
	output bb_pkg::win_item_t head
);
	import bb_pkg::*;

	win_item_t        mem [QUEUE_DEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;

	assign valid = count_q != '0;
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr.valid) begin
			mem[wr_ptr_q] <= wr.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.valid) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			count_q <= count_q + QCW'(wr.valid) - QCW'(pop);
		end
	end

endmodule

// ----- sv/bb_back.sv -----
// ----------------------------------------------------------------------------
// bb_back
// Arithmetic back end: nine-sample channel sums, then rounded divide by nine
// through a reciprocal multiply, into the result register.
// ----------------------------------------------------------------------------
module bb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  bb_pkg::win_item_t q_item,
	output logic              q_pop,
	output logic              empty,
	input  logic              pop,
	output bb_pkg::result_t   result
);
	import bb_pkg::*;

	function automatic logic [7:0] mean9(input logic [SUM_W-1:0] s);
		logic [12:0] b;
		logic [25:0] p;
		b = 13'(s) + ROUND_BIAS;
		p = 26'(b) * 26'(RECIP_NINE);
		return p[RECIP_SHIFT +: 8];
	endfunction

	logic [SUM_W-1:0] sum_r;
	logic [SUM_W-1:0] sum_g;
	logic [SUM_W-1:0] sum_b;

	logic             v_b1;
	logic [SUM_W-1:0] sum_r_b1;
	logic [SUM_W-1:0] sum_g_b1;
	logic [SUM_W-1:0] sum_b_b1;
	logic [10:0]      ccol_b1;
	logic [11:0]      crow_b1;

	logic             out_v_q;
	result_t          result_q;

	logic             out_rdy;
	logic             b1_rdy;

	assign out_rdy = !out_v_q || pop;
	assign b1_rdy  = !v_b1 || out_rdy;
	assign q_pop   = q_valid && b1_rdy;
	assign empty   = !out_v_q;
	assign result  = result_q;

	always_comb begin
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		for (int i = 0; i < 9; i++) begin
			sum_r = sum_r + SUM_W'(q_item.win[i].red_in);
			sum_g = sum_g + SUM_W'(q_item.win[i].green_in);
			sum_b = sum_b + SUM_W'(q_item.win[i].blue_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (b1_rdy) begin
				v_b1 <= q_valid;
			end
			if (out_rdy) begin
				out_v_q <= v_b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			sum_r_b1 <= sum_r;
			sum_g_b1 <= sum_g;
			sum_b_b1 <= sum_b;
			ccol_b1  <= q_item.center_column;
			crow_b1  <= q_item.center_row;
		end
		if (out_rdy && v_b1) begin
			result_q.red_out       <= mean9(sum_r_b1);
			result_q.green_out     <= mean9(sum_g_b1);
			result_q.blue_out      <= mean9(sum_b_b1);
			result_q.center_column <= ccol_b1;
			result_q.center_row    <= crow_b1;
		end
	end

endmodule

// ----- sv/rgb_box_blur_3x3.sv -----
// Path: intake registers, queue, channel-sum register, then result register.
// Throughput: one pixel per clock while full is low; each line store does one read and one
// write per pixel, and the window slides by one column per pixel.
// Reset: width 640, height 480, counters at zero, queue and result empty;
// line stores and window are not cleared.
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3
// Streaming 3x3 box blur on RGB pixels in raster order; one rounded mean per
// interior pixel, tagged with its column and row.
// ----------------------------------------------------------------------------
module rgb_box_blur_3x3 #(
	parameter int unsigned MAX_WIDTH = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  bb_pkg::pixel_t                  pixel,
	output logic                            empty,
	input  logic                            pop,
	output bb_pkg::result_t                 result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bb_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bb_pkg::*;

	win_push_t q_push;
	logic      q_pop;
	logic      q_valid;
	win_item_t q_head;

	bb_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pixel     (pixel),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_pop     (q_pop),
		.q_push    (q_push)
	);

	bb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.pop    (q_pop),
		.valid  (q_valid),
		.head   (q_head)
	);

	bb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_head),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

// ----- sv/bb_checker.sv -----
// ----------------------------------------------------------------------------
// bb_checker
// Port-level checks on the box blur: reset state, full only after an accepted
// word, and a waiting result word holds until popped.
// ----------------------------------------------------------------------------
module bb_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            push,
	input logic            full,
	input logic            empty,
	input logic            pop,
	input bb_pkg::result_t result
);
	import bb_pkg::*;

	a_reset_state: assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("outputs not idle during reset");

	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without an accepted word");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result word changed or dropped");

endmodule

bind rgb_box_blur_3x3 bb_checker u_bb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
